// ===== src/ohp_pkg.sv =====
package ohp_pkg;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_MAGIC,
		PH_HASH,
		PH_TYPE,
		PH_ALEN,
		PH_AUTHOR,
		PH_TS,
		PH_NDIMS,
		PH_DIM,
		PH_DTYPE,
		PH_CLEN,
		PH_STOP
	} phase_t;

	localparam logic [2:0] KIND_TYPE   = 3'd0;
	localparam logic [2:0] KIND_AUTHOR = 3'd1;
	localparam logic [2:0] KIND_NDIMS  = 3'd2;
	localparam logic [2:0] KIND_DIM    = 3'd3;
	localparam logic [2:0] KIND_DTYPE  = 3'd4;
	localparam logic [2:0] KIND_CLEN   = 3'd5;
	localparam logic [2:0] KIND_DONE   = 3'd6;
	localparam logic [2:0] KIND_ERROR  = 3'd7;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MAGIC     = 2'd1;
	localparam logic [1:0] ERR_DIMS      = 2'd2;
	localparam logic [1:0] ERR_EARLY_END = 2'd3;

	localparam logic [31:0] MAGIC_RESET = 32'h4E4D_4C02;

	// skip field lengths, counted as last byte index
	localparam logic [2:0] SKIP_LAST = 3'd7;
	localparam logic [2:0] WORD_LAST = 3'd3;
	localparam logic [5:0] AUTHOR_MAX = 6'd63;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [2:0]  dim_index;
		logic [1:0]  error_code;
		logic        last;
	} res_t;

endpackage

// ===== src/object_header_parser.sv =====
// Object header parser: one stream byte per transfer, tagged field results out.
// With the result queue empty, a result is offered on the master side in the cycle after
// the byte's transfer. Throughput: one byte per cycle while ready is high; the last
// content-length byte yields two results, drained one per cycle while m_axis_tready is
// high from a four-entry result queue, and ready drops while fewer than two are free.
// Reset: arst_n clears the parser to idle, empties the result queue and loads the
// magic register with 0x4E4D4C02; bytes before an object start are dropped.
module object_header_parser import ohp_pkg::*; #(
	parameter int MAX_DIMS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_axis_tuser,   // [0] object_start, [1] stream_end
	// result stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] value, [34:32] dim_index,
	                                    // [36:35] error_code, [39:37] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] kind
	output logic        m_axis_tlast,   // last result of the header
	// magic register write
	input  logic        magic_we,
	input  logic [31:0] magic_wdata
);

	logic [31:0] magic_q;
	logic        in_xfer;
	logic        push0, push1;
	res_t        res0, res1;
	res_t        head;
	logic        room2;

	// Load the expected magic on every write; the fourth magic byte compares
	// against whatever value is held when it arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
		end else if (magic_we) begin
			magic_q <= magic_wdata;
		end
	end

	// Take a byte whenever the queue can absorb the worst case of two results,
	// even while up to two results are still waiting downstream.
	assign s_axis_tready = room2;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// Advance the header state machine once per accepted byte.
	ohp_core #(
		.MAX_DIMS(MAX_DIMS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (in_xfer),
		.data_byte    (s_axis_tdata),
		.object_start (s_axis_tuser[0]),
		.stream_end   (s_axis_tuser[1]),
		.magic        (magic_q),
		.push0        (push0),
		.push1        (push1),
		.res0         (res0),
		.res1         (res1)
	);

	// Queue results so the byte side keeps moving while the master side stalls.
	ohp_rfifo u_rfifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0 && in_xfer),
		.push1  (push1 && in_xfer),
		.res0   (res0),
		.res1   (res1),
		.pop    (m_axis_tvalid && m_axis_tready),
		.room2  (room2),
		.valid  (m_axis_tvalid),
		.head   (head)
	);

	assign m_axis_tdata = {3'b000, head.error_code, head.dim_index, head.value};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

// ===== src/ohp_core.sv =====
module ohp_core import ohp_pkg::*; #(
	parameter int MAX_DIMS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        object_start,
	input  logic        stream_end,
	input  logic [31:0] magic,
	output logic        push0,
	output logic        push1,
	output res_t        res0,
	output res_t        res1
);

	localparam int DW = $clog2(MAX_DIMS + 1);

	phase_t       phase_q, ph, phase_n;
	logic [2:0]   fcnt_q, fc, fc_n;
	logic [31:0]  word_q, wd, wd_n, shw;
	logic [7:0]   arem_q, ar, ar_n;
	logic [5:0]   aemit_q, ae, ae_n;
	logic [DW-1:0] dtot_q, dt, dt_n;
	logic [DW-1:0] ddone_q, dd, dd_n;
	logic [15:0]  boff_q, bo, bo_n;

	always_comb begin
		ph  = object_start ? PH_MAGIC : phase_q;
		fc  = object_start ? '0 : fcnt_q;
		wd  = object_start ? '0 : word_q;
		ar  = object_start ? '0 : arem_q;
		ae  = object_start ? '0 : aemit_q;
		dt  = object_start ? '0 : dtot_q;
		dd  = object_start ? '0 : ddone_q;
		bo  = object_start ? '0 : boff_q;
		phase_n = ph;
		fc_n = fc;
		wd_n = wd;
		ar_n = ar;
		ae_n = ae;
		dt_n = dt;
		dd_n = dd;
		bo_n = bo;
		shw  = {wd[23:0], data_byte};
		push0 = 1'b0;
		push1 = 1'b0;
		res0 = '0;
		res1 = '0;
		if (ph == PH_IDLE || ph == PH_STOP) begin
			phase_n = ph;
		end else if (stream_end) begin
			phase_n = PH_STOP;
			push0 = 1'b1;
			res0.kind = KIND_ERROR;
			res0.error_code = ERR_EARLY_END;
			res0.last = 1'b1;
		end else begin
			bo_n = bo + 16'd1;
			case (ph)
				PH_MAGIC: begin
					wd_n = shw;
					if (fc == WORD_LAST) begin
						fc_n = '0;
						if (shw != magic) begin
							phase_n = PH_STOP;
							push0 = 1'b1;
							res0.kind = KIND_ERROR;
							res0.error_code = ERR_MAGIC;
							res0.last = 1'b1;
						end else begin
							wd_n = '0;
							phase_n = PH_HASH;
						end
					end else begin
						fc_n = fc + 3'd1;
					end
				end
				PH_HASH, PH_TS: begin
					if (fc == SKIP_LAST) begin
						fc_n = '0;
						phase_n = (ph == PH_HASH) ? PH_TYPE : PH_NDIMS;
					end else begin
						fc_n = fc + 3'd1;
					end
				end
				PH_TYPE: begin
					phase_n = PH_ALEN;
					push0 = 1'b1;
					res0.kind = KIND_TYPE;
					res0.value = 32'(data_byte);
				end
				PH_ALEN: begin
					ar_n = data_byte;
					ae_n = '0;
					phase_n = (data_byte == 8'd0) ? PH_TS : PH_AUTHOR;
				end
				PH_AUTHOR: begin
					if (ae < AUTHOR_MAX) begin
						ae_n = ae + 6'd1;
						push0 = 1'b1;
						res0.kind = KIND_AUTHOR;
						res0.value = 32'(data_byte);
					end
					ar_n = ar - 8'd1;
					if (ar_n == 8'd0) begin
						phase_n = PH_TS;
					end
				end
				PH_NDIMS: begin
					push0 = 1'b1;
					if (int'(data_byte) > MAX_DIMS) begin
						phase_n = PH_STOP;
						res0.kind = KIND_ERROR;
						res0.error_code = ERR_DIMS;
						res0.last = 1'b1;
					end else begin
						dt_n = DW'(data_byte);
						dd_n = '0;
						fc_n = '0;
						wd_n = '0;
						phase_n = (data_byte == 8'd0) ? PH_DTYPE : PH_DIM;
						res0.kind = KIND_NDIMS;
						res0.value = 32'(data_byte);
					end
				end
				PH_DIM: begin
					wd_n = shw;
					if (fc == WORD_LAST) begin
						fc_n = '0;
						wd_n = '0;
						dd_n = dd + DW'(1);
						if (dd_n >= dt) begin
							phase_n = PH_DTYPE;
						end
						push0 = 1'b1;
						res0.kind = KIND_DIM;
						res0.value = shw;
						res0.dim_index = 3'(dd);
					end else begin
						fc_n = fc + 3'd1;
					end
				end
				PH_DTYPE: begin
					fc_n = '0;
					wd_n = '0;
					phase_n = PH_CLEN;
					push0 = 1'b1;
					res0.kind = KIND_DTYPE;
					res0.value = 32'(data_byte);
				end
				PH_CLEN: begin
					wd_n = shw;
					if (fc == WORD_LAST) begin
						fc_n = '0;
						phase_n = PH_STOP;
						push0 = 1'b1;
						push1 = 1'b1;
						res0.kind = KIND_CLEN;
						res0.value = shw;
						res1.kind = KIND_DONE;
						res1.value = 32'(bo_n);
						res1.last = 1'b1;
					end else begin
						fc_n = fc + 3'd1;
					end
				end
				default: begin
					phase_n = PH_STOP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fcnt_q  <= '0;
			word_q  <= '0;
			arem_q  <= '0;
			aemit_q <= '0;
			dtot_q  <= '0;
			ddone_q <= '0;
			boff_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			fcnt_q  <= fc_n;
			word_q  <= wd_n;
			arem_q  <= ar_n;
			aemit_q <= ae_n;
			dtot_q  <= dt_n;
			ddone_q <= dd_n;
			boff_q  <= bo_n;
		end
	end

endmodule

// ===== src/ohp_rfifo.sv =====
module ohp_rfifo import ohp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push0,
	input  logic push1,
	input  res_t res0,
	input  res_t res1,
	input  logic pop,
	output logic room2,
	output logic valid,
	output res_t head
);

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   count_q;
	logic [AW:0]   npush;

	assign npush = push1 ? (AW+1)'(2) : (push0 ? (AW+1)'(1) : '0);
	assign valid = (count_q != '0);
	assign room2 = (count_q <= (AW+1)'(DEPTH - 2));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(npush);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + npush - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= res0;
		end
		if (push1) begin
			mem_q[wr_q + AW'(1)] <= res1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("result queue over capacity");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second result pushed without first");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> room2)
		else $error("result pushed without room for two");

	a_pop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push0) |=> (count_q == $past(count_q) - (AW+1)'(1)))
		else $error("queue count did not drop on pop");
`endif

endmodule

// ===== tb/ohp_result_checker.sv =====
`timescale 1ns / 100ps

module ohp_result_checker import ohp_pkg::*; #(
	parameter int MAX_DIMS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        magic_we,
	input  logic [31:0] magic_wdata,
	output int          fail_count,
	output int          pending
);

	res_t        fields_due[$];
	logic [31:0] magic;
	phase_t      ph;
	logic [2:0]  fcnt;
	logic [31:0] word;
	logic [7:0]  arem;
	logic [5:0]  aemit;
	logic [7:0]  dtot;
	logic [7:0]  ddone;
	logic [15:0] boff;

	function automatic void emit(input logic [2:0] k, input logic [31:0] v,
		input logic [2:0] d, input logic [1:0] e, input logic l);
		res_t r;
		r.kind       = k;
		r.value      = v;
		r.dim_index  = d;
		r.error_code = e;
		r.last       = l;
		fields_due.push_back(r);
	endfunction

	function automatic void clear_walk();
		fcnt  = '0;
		word  = '0;
		arem  = '0;
		aemit = '0;
		dtot  = '0;
		ddone = '0;
		boff  = '0;
	endfunction

	// expected results of one header byte
	function automatic void parse_byte(input logic [7:0] b, input logic st, input logic en);
		if (st) begin
			clear_walk();
			ph = PH_MAGIC;
		end
		if (ph == PH_IDLE || ph == PH_STOP)
			return;
		if (en) begin
			ph = PH_STOP;
			emit(KIND_ERROR, '0, '0, ERR_EARLY_END, 1'b1);
			return;
		end
		boff = boff + 16'd1;
		case (ph)
			PH_MAGIC: begin
				word = {word[23:0], b};
				if (fcnt == WORD_LAST) begin
					fcnt = '0;
					if (word != magic) begin
						ph = PH_STOP;
						emit(KIND_ERROR, '0, '0, ERR_MAGIC, 1'b1);
					end else begin
						word = '0;
						ph = PH_HASH;
					end
				end else
					fcnt = fcnt + 3'd1;
			end
			PH_HASH, PH_TS: begin
				if (fcnt == SKIP_LAST) begin
					fcnt = '0;
					ph = (ph == PH_HASH) ? PH_TYPE : PH_NDIMS;
				end else
					fcnt = fcnt + 3'd1;
			end
			PH_TYPE: begin
				ph = PH_ALEN;
				emit(KIND_TYPE, {24'd0, b}, '0, ERR_NONE, 1'b0);
			end
			PH_ALEN: begin
				arem = b;
				aemit = '0;
				ph = (b == 8'd0) ? PH_TS : PH_AUTHOR;
			end
			PH_AUTHOR: begin
				if (aemit < AUTHOR_MAX) begin
					aemit = aemit + 6'd1;
					emit(KIND_AUTHOR, {24'd0, b}, '0, ERR_NONE, 1'b0);
				end
				arem = arem - 8'd1;
				if (arem == 8'd0)
					ph = PH_TS;
			end
			PH_NDIMS: begin
				if (b > MAX_DIMS) begin
					ph = PH_STOP;
					emit(KIND_ERROR, '0, '0, ERR_DIMS, 1'b1);
				end else begin
					dtot = b;
					ddone = '0;
					fcnt = '0;
					word = '0;
					ph = (b == 8'd0) ? PH_DTYPE : PH_DIM;
					emit(KIND_NDIMS, {24'd0, b}, '0, ERR_NONE, 1'b0);
				end
			end
			PH_DIM: begin
				word = {word[23:0], b};
				if (fcnt == WORD_LAST) begin
					emit(KIND_DIM, word, ddone[2:0], ERR_NONE, 1'b0);
					fcnt = '0;
					word = '0;
					ddone = ddone + 8'd1;
					if (ddone >= dtot)
						ph = PH_DTYPE;
				end else
					fcnt = fcnt + 3'd1;
			end
			PH_DTYPE: begin
				fcnt = '0;
				word = '0;
				ph = PH_CLEN;
				emit(KIND_DTYPE, {24'd0, b}, '0, ERR_NONE, 1'b0);
			end
			PH_CLEN: begin
				word = {word[23:0], b};
				if (fcnt == WORD_LAST) begin
					fcnt = '0;
					ph = PH_STOP;
					emit(KIND_CLEN, word, '0, ERR_NONE, 1'b0);
					emit(KIND_DONE, {16'd0, boff}, '0, ERR_NONE, 1'b1);
				end else
					fcnt = fcnt + 3'd1;
			end
			default: ph = PH_STOP;
		endcase
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t: %s got 'h%0h, want 'h%0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			fields_due.delete();
			fail_count = 0;
			magic = MAGIC_RESET;
			ph = PH_IDLE;
			clear_walk();
		end else begin
			// check results first so a missing one never pairs with a fresh prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (fields_due.size() == 0)
					report("unexpected result, kind", {29'd0, m_axis_tuser}, '0);
				else begin
					want = fields_due.pop_front();
					if (m_axis_tuser !== want.kind)
						report("kind", {29'd0, m_axis_tuser}, {29'd0, want.kind});
					if (m_axis_tdata[31:0] !== want.value)
						report("value", m_axis_tdata[31:0], want.value);
					if (m_axis_tdata[34:32] !== want.dim_index)
						report("dim_index", {29'd0, m_axis_tdata[34:32]}, {29'd0, want.dim_index});
					if (m_axis_tdata[36:35] !== want.error_code)
						report("error_code", {30'd0, m_axis_tdata[36:35]},
							{30'd0, want.error_code});
					if (m_axis_tdata[39:37] !== 3'd0)
						report("pad bits", {29'd0, m_axis_tdata[39:37]}, '0);
					if (m_axis_tlast !== want.last)
						report("last", {31'd0, m_axis_tlast}, {31'd0, want.last});
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
			if (magic_we)
				magic = magic_wdata;
		end
		pending = fields_due.size();
	end

endmodule

// ===== tb/object_header_parser_tb.sv =====
`timescale 1ns / 100ps

module object_header_parser_tb import ohp_pkg::*; ();

	localparam int MAX_DIMS = 8;
	localparam int ITEM_GOAL = 850;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic [1:0]  s_axis_tuser;   // [0] object_start, [1] stream_end
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [31:0] value, [34:32] dim_index, [36:35] error_code
	logic [2:0]  m_axis_tuser;   // [2:0] kind
	logic        m_axis_tlast;
	logic        magic_we;
	logic [31:0] magic_wdata;

	int          fail_count;
	int          pending;

	// stimulus side copy of the magic register, used to build good headers
	logic [31:0] cur_magic;
	// both sides skip their random gaps while this is set
	bit          calm;
	// ask the receiver for one long hold-off; it clears this itself
	bit          hold_req;
	int          sent_items;

	object_header_parser #(.MAX_DIMS(MAX_DIMS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.magic_we      (magic_we),
		.magic_wdata   (magic_wdata)
	);

	ohp_result_checker #(.MAX_DIMS(MAX_DIMS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.magic_we      (magic_we),
		.magic_wdata   (magic_wdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one byte: optional gap with valid low, then hold valid and data until the
	// transfer. Inputs move on the falling edge; tready is read at the rising edge.
	task automatic put_byte(input logic [7:0] b, input logic st, input logic en);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= {en, st};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Drop valid and hold off until every predicted result has been taken, then let
	// the block settle bytes that produce nothing.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	// Rewrite the magic register while nothing is in flight.
	task automatic load_magic(input logic [31:0] v);
		drain();
		magic_we    <= 1'b1;
		magic_wdata <= v;
		@(negedge clk);
		magic_we    <= 1'b0;
		cur_magic = v;
	endtask

	function automatic logic [31:0] word_pick();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0001;
			default: return $urandom;
		endcase
	endfunction

	// Build one header and send it. A wrong magic flips one bit of the register value;
	// a cut replaces a random byte of the header with the stream end.
	task automatic send_object(input int alen, input int ndims, input bit wrong_magic,
		input bit cut_mode);
		logic [7:0]  hdr[$];
		logic [31:0] m;
		logic [31:0] w;
		int          cut;
		m = cur_magic;
		if (wrong_magic)
			m = m ^ (32'h1 << $urandom_range(0, 31));
		for (int i = 3; i >= 0; i--)
			hdr.push_back(m[8*i +: 8]);
		repeat (8) hdr.push_back(8'($urandom_range(0, 255)));   // hash
		hdr.push_back(8'($urandom_range(0, 255)));              // object type
		hdr.push_back(alen[7:0]);
		repeat (alen[7:0]) hdr.push_back(8'($urandom_range(0, 255)));
		repeat (8) hdr.push_back(8'($urandom_range(0, 255)));   // timestamp
		hdr.push_back(ndims[7:0]);
		if (ndims[7:0] <= MAX_DIMS) begin
			repeat (ndims[7:0]) begin
				w = word_pick();
				for (int i = 3; i >= 0; i--)
					hdr.push_back(w[8*i +: 8]);
			end
			hdr.push_back(8'($urandom_range(0, 255)));          // data type
			w = word_pick();
			for (int i = 3; i >= 0; i--)
				hdr.push_back(w[8*i +: 8]);
		end
		cut = cut_mode ? $urandom_range(0, hdr.size() - 1) : -1;
		for (int i = 0; i < hdr.size(); i++) begin
			sent_items++;
			if (i == cut) begin
				put_byte(8'($urandom_range(0, 255)), i == 0, 1'b1);
				break;
			end
			put_byte(hdr[i], i == 0, 1'b0);
		end
	endtask

	// Stray bytes; with may_start some of them open a junk object.
	task automatic send_noise(input int n, input bit may_start);
		repeat (n)
			put_byte(8'($urandom_range(0, 255)), may_start && ($urandom_range(0, 2) == 0),
				1'($urandom_range(0, 1)));
	endtask

	// Receiver: random stall per result, plus one long hold-off on request.
	initial begin : receiver
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int          choice;
		int          obj_count;
		int          cfg_step;
		logic [31:0] v;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		magic_we      = 1'b0;
		magic_wdata   = '0;
		cur_magic     = MAGIC_RESET;
		calm          = 1'b0;
		hold_req      = 1'b0;
		sent_items    = 0;
		obj_count     = 0;
		cfg_step      = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: bytes and stream end before any object are dropped
		put_byte(8'hFF, 1'b0, 1'b0);
		put_byte(8'h00, 1'b0, 1'b1);
		// start and end on the same byte, then a byte after the stop
		put_byte(8'hA5, 1'b1, 1'b1);
		put_byte(8'h55, 1'b0, 1'b0);
		// stream ends before the magic word is complete
		put_byte(cur_magic[31:24], 1'b1, 1'b0);
		put_byte(cur_magic[23:16], 1'b0, 1'b0);
		put_byte(8'h00, 1'b0, 1'b1);
		// bad magic
		repeat (4) put_byte(8'h00, 1'b0, 1'b0);
		put_byte(8'h00, 1'b1, 1'b0);
		repeat (3) put_byte(8'h00, 1'b0, 1'b0);
		// magic rewritten between the second and third magic byte: the new value counts
		put_byte(8'h12, 1'b1, 1'b0);
		put_byte(8'h34, 1'b0, 1'b0);
		load_magic(32'h1234_5678);
		put_byte(8'h56, 1'b0, 1'b0);
		put_byte(8'h78, 1'b0, 1'b0);
		put_byte(8'hEE, 1'b0, 1'b1);

		// fixed shapes: empty author and no dimensions, the author limit, all dimensions
		send_object(0, 0, 1'b0, 1'b0);
		send_object(63, 1, 1'b0, 1'b0);
		// stall the output for a long stretch while a long author streams in
		calm = 1'b1;
		hold_req = 1'b1;
		send_object(80, MAX_DIMS, 1'b0, 1'b0);
		calm = 1'b0;
		// sender pauses until every result is back
		drain();
		send_object(255, 2, 1'b0, 1'b0);
		send_object(3, MAX_DIMS + 1, 1'b0, 1'b0);
		send_object(1, 255, 1'b0, 1'b0);

		// random part: mostly well-formed headers, some broken ones and noise
		while (sent_items < ITEM_GOAL) begin
			calm = ($urandom_range(0, 3) == 0);
			choice = $urandom_range(0, 19);
			case (choice)
				0: send_noise($urandom_range(1, 5), 1'b0);
				1: send_noise($urandom_range(1, 6), 1'b1);
				2: send_object($urandom_range(0, 6), $urandom_range(0, MAX_DIMS), 1'b1, 1'b0);
				3: send_object($urandom_range(0, 6), $urandom_range(MAX_DIMS + 1, 255), 1'b0,
					1'b0);
				4, 5, 6: send_object($urandom_range(0, 12), $urandom_range(0, MAX_DIMS), 1'b0,
					1'b1);
				default: send_object(($urandom_range(0, 9) == 0) ? $urandom_range(60, 255)
					: $urandom_range(0, 12), $urandom_range(0, MAX_DIMS), 1'b0, 1'b0);
			endcase
			if ($urandom_range(0, 3) == 0)
				send_noise($urandom_range(1, 3), 1'b0);
			obj_count++;
			// new magic every few objects; extremes and the reset value come first
			if (obj_count % 5 == 0) begin
				case (cfg_step)
					0: v = 32'h0000_0000;
					1: v = 32'hFFFF_FFFF;
					2: v = MAGIC_RESET;
					default: v = ($urandom_range(0, 2) == 0) ? word_pick() : $urandom;
				endcase
				cfg_step++;
				load_magic(v);
			end
		end

		// wait for the last results, then watch a little longer for strays
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("object_header_parser_tb OK");
		else
			$display("object_header_parser_tb NOT OK");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("object_header_parser_tb NOT OK");
		$finish;
	end

endmodule
